### rtl/greedy_spatial_task_worker_matcher_top_defines.svh
// Assertion macros shared by the RTL files.
`ifndef GREEDY_SPATIAL_TASK_WORKER_MATCHER_TOP_DEFINES_SVH
`define GREEDY_SPATIAL_TASK_WORKER_MATCHER_TOP_DEFINES_SVH

`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/gstwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gstwm_pkg;
	localparam int TableDepth = 256;
	localparam int MaxCopies = 16;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);
	localparam int CopyW = 5;

	typedef struct packed {
		logic        cmd;
		logic [19:0] arrival_time;
		logic [19:0] duration;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] reach;
		logic [15:0] value;
		logic [4:0]  copies;
	} in_item_t;

	typedef struct packed {
		logic        matched;
		logic [7:0]  partner_index;
		logic [31:0] pair_value;
		logic [47:0] total_utility;
		logic        table_full;
		logic        copy_last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_COPY, ST_SCAN, ST_DRAIN, ST_COMMIT, ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic start_copy;
		logic scan;
		logic commit;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic scan_done;
		logic pipe_empty;
		logic last_copy;
		logic zero_copies;
	} stat_t;
endpackage
`default_nettype wire

### rtl/gstwm_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface gstwm_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/gstwm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "greedy_spatial_task_worker_matcher_top_defines.svh"
module gstwm_ctrl import gstwm_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  wire   out_ready,
	input  stat_t st,
	output cmd_t  cm
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_COPY;
			ST_COPY: begin
				if (st.zero_copies) state_d = ST_IDLE;
				else if (st.full) state_d = ST_COMMIT;
				else state_d = ST_SCAN;
			end
			ST_SCAN: if (st.scan_done) state_d = ST_DRAIN;
			ST_DRAIN: if (st.pipe_empty) state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_OUT;
			ST_OUT: if (out_ready) state_d = st.last_copy ? ST_IDLE : ST_COPY;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cm = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cm.load = in_valid;
			end
			ST_COPY: cm.start_copy = !st.zero_copies;
			ST_SCAN: cm.scan = 1'b1;
			ST_DRAIN: cm.scan = 1'b0;
			ST_COMMIT: cm.commit = 1'b1;
			ST_OUT: begin
				out_valid = 1'b1;
				cm.emit = out_ready;
			end
			default: cm = '0;
		endcase
	end

	`ASSERT_IMPL(a_ready_idle, clk, arst_n, in_ready, state_q == ST_IDLE)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`ASSERT_NEXT(a_scan_drain, clk, arst_n, state_q == ST_SCAN && st.scan_done,
		state_q == ST_DRAIN)
endmodule
`default_nettype wire

### rtl/gstwm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "greedy_spatial_task_worker_matcher_top_defines.svh"
module gstwm_datapath import gstwm_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	input  in_item_t  in_data,
	input  cmd_t      cm,
	output stat_t     st,
	output out_item_t out_data
);
	// Worker table: {x, y, radius, start, duration, rate}; task table: {x, y, start, dur, pay}.
	logic [103:0] wmem [TableDepth];
	logic [87:0]  tmem [TableDepth];
	logic         wused_q [TableDepth];
	logic         tused_q [TableDepth];

	in_item_t     it_q;
	logic [CopyW-1:0] left_q;
	logic [CopyW-1:0] nsat;
	logic [CntW-1:0] tcnt_q, wcnt_q, mycnt, othcnt;
	logic [IdxW-1:0] me_q;
	logic [CntW-1:0] scan_q;
	logic         full_q;
	logic [47:0]  util_q;
	logic         best_v_q;
	logic [31:0]  best_q;
	logic [IdxW-1:0] bidx_q;

	logic          s1_v;
	logic [IdxW-1:0] s1_i;
	logic [103:0]  w_s1;
	logic [87:0]   t_s1;
	logic          u_s1;
	logic          rd;
	logic [IdxW-1:0] ra;
	logic          s2_v, s3_v;
	logic [IdxW-1:0] s2_i, s3_i;
	logic [33:0]   d2_s2;
	logic [31:0]   r2_s2;
	logic          ok_s2, ok_s3;
	logic [31:0]   p_s2, s3_c;
	logic [15:0]   dx, dy;
	logic [20:0]   we, te;

	assign nsat = (in_data.copies > CopyW'(MaxCopies)) ? CopyW'(MaxCopies) : in_data.copies;
	assign mycnt = it_q.cmd ? wcnt_q : tcnt_q;
	assign othcnt = it_q.cmd ? tcnt_q : wcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcnt_q <= '0;
			wcnt_q <= '0;
			util_q <= '0;
			left_q <= '0;
		end else begin
			if (cm.load) left_q <= in_data.cmd ? nsat : CopyW'(1);
			if (cm.start_copy && mycnt != CntW'(TableDepth)) begin
				if (it_q.cmd) wcnt_q <= wcnt_q + 1'b1;
				else tcnt_q <= tcnt_q + 1'b1;
			end
			if (cm.commit && best_v_q && !full_q) util_q <= util_q + 48'(best_q);
			if (cm.emit) left_q <= left_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cm.load) it_q <= in_data;
		if (cm.start_copy) begin
			full_q <= (mycnt == CntW'(TableDepth));
			me_q <= mycnt[IdxW-1:0];
			scan_q <= '0;
			best_v_q <= 1'b0;
			best_q <= '0;
			if (mycnt != CntW'(TableDepth)) begin
				if (it_q.cmd) begin
					wmem[mycnt[IdxW-1:0]] <= {it_q.pos_x, it_q.pos_y, it_q.reach,
						it_q.arrival_time, it_q.duration, it_q.value};
					wused_q[mycnt[IdxW-1:0]] <= 1'b0;
				end else begin
					tmem[mycnt[IdxW-1:0]] <= {it_q.pos_x, it_q.pos_y,
						it_q.arrival_time, it_q.duration, it_q.value};
					tused_q[mycnt[IdxW-1:0]] <= 1'b0;
				end
			end
		end
		if (cm.scan && scan_q != othcnt) scan_q <= scan_q + 1'b1;
		if (cm.commit && best_v_q && !full_q) begin
			if (it_q.cmd) begin
				wused_q[me_q] <= 1'b1;
				tused_q[bidx_q] <= 1'b1;
			end else begin
				tused_q[me_q] <= 1'b1;
				wused_q[bidx_q] <= 1'b1;
			end
		end
		if (s3_v && ok_s3 && s3_c > best_q) begin
			best_q <= s3_c;
			bidx_q <= s3_i;
			best_v_q <= 1'b1;
		end
	end

	// Stage 1: registered table reads.
	assign rd = cm.scan && scan_q != othcnt;
	assign ra = scan_q[IdxW-1:0];

	always_ff @(posedge clk) begin
		w_s1 <= wmem[it_q.cmd ? me_q : ra];
		t_s1 <= tmem[it_q.cmd ? ra : me_q];
		u_s1 <= it_q.cmd ? tused_q[ra] : wused_q[ra];
		s1_i <= ra;
	end

	// Stage 2: distances, window test, product.
	always_comb begin
		dx = (w_s1[103:88] > t_s1[87:72]) ? w_s1[103:88] - t_s1[87:72]
			: t_s1[87:72] - w_s1[103:88];
		dy = (w_s1[87:72] > t_s1[71:56]) ? w_s1[87:72] - t_s1[71:56]
			: t_s1[71:56] - w_s1[87:72];
		we = 21'(w_s1[55:36]) + 21'(w_s1[35:16]);
		te = 21'(t_s1[55:36]) + 21'(t_s1[35:16]);
	end

	always_ff @(posedge clk) begin
		s2_i <= s1_i;
		d2_s2 <= 34'(dx * dx) + 34'(dy * dy);
		r2_s2 <= w_s1[71:56] * w_s1[71:56];
		ok_s2 <= !u_s1 && (21'(w_s1[55:36]) < te) && (21'(t_s1[55:36]) < we);
		p_s2 <= t_s1[15:0] * w_s1[15:0];
		s3_i <= s2_i;
		ok_s3 <= ok_s2 && (d2_s2 <= 34'(r2_s2));
		s3_c <= p_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
			s2_v <= 1'b0;
			s3_v <= 1'b0;
		end else begin
			s1_v <= rd;
			s2_v <= s1_v;
			s3_v <= s2_v && ok_s2;
		end
	end

	assign st.full = (mycnt == CntW'(TableDepth));
	assign st.scan_done = (scan_q == othcnt);
	assign st.pipe_empty = !s1_v && !s2_v && !s3_v;
	assign st.last_copy = (left_q == CopyW'(1));
	assign st.zero_copies = (left_q == '0);

	logic mt;
	assign mt = best_v_q && !full_q;
	assign out_data.matched = mt;
	assign out_data.partner_index = mt ? 8'(bidx_q) : 8'd0;
	assign out_data.pair_value = mt ? best_q : 32'd0;
	assign out_data.total_utility = util_q;
	assign out_data.table_full = full_q;
	assign out_data.copy_last = (left_q == CopyW'(1));

	`ASSERT_IMPL(a_cnt_t, clk, arst_n, 1'b1, tcnt_q <= CntW'(TableDepth))
	`ASSERT_IMPL(a_cnt_w, clk, arst_n, 1'b1, wcnt_q <= CntW'(TableDepth))
	`ASSERT_IMPL(a_full_nomatch, clk, arst_n, cm.emit && full_q, !out_data.matched)
endmodule
`default_nettype wire

### rtl/greedy_spatial_task_worker_matcher_top.sv
// Channel | Role  | Payload
// in      | sink  | in_item_t (one arrival)
// out     | source| out_item_t (one result per copy)
// Each copy scans the opposite table: the scan reads one stored
// entry a cycle through a three-stage compare pipeline, then drains and commits.
// An arrival is taken only when all results of the previous one are delivered.
// A stalled result holds in its register; reset clears counts and utility.
// Table contents are not cleared; only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none
module greedy_spatial_task_worker_matcher_top import gstwm_pkg::*; (
	input wire clk,
	input wire arst_n,
	gstwm_stream_if.sink   in_ch,
	gstwm_stream_if.source out_ch
);
	cmd_t  cm;
	stat_t st;

	gstwm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.st(st), .cm(cm)
	);

	gstwm_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_data(in_ch.data), .cm(cm), .st(st), .out_data(out_ch.data)
	);
endmodule
`default_nettype wire

### dv/tb_greedy_spatial_task_worker_matcher_top.sv
`timescale 1ns / 1ps
module tb_greedy_spatial_task_worker_matcher_top;
	import gstwm_pkg::*;

	localparam int Depth = 256;
	localparam int Copies = 16;
	localparam longint CycleLimit = 10000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	gstwm_stream_if #(.payload_t(in_item_t)) in_ch ();
	gstwm_stream_if #(.payload_t(out_item_t)) out_ch ();

	greedy_spatial_task_worker_matcher_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #4 clk = ~clk;

	// Predictor state: the two tables and the running utility.
	logic [31:0] w_pos [Depth];
	logic [15:0] w_rad [Depth];
	logic [19:0] w_start [Depth];
	logic [20:0] w_end [Depth];
	logic [15:0] w_rate [Depth];
	bit w_used [Depth];
	logic [31:0] t_pos [Depth];
	logic [19:0] t_start [Depth];
	logic [20:0] t_end [Depth];
	logic [15:0] t_pay [Depth];
	bit t_used [Depth];
	int n_tasks;
	int n_workers;
	logic [47:0] utility;

	in_item_t pending_items [$];
	out_item_t expected_results [$];
	int errors;
	longint cycles;
	bit stim_done;
	bit calm;

	task automatic add_item(input in_item_t a);
		pending_items.insert(pending_items.size(), a);
	endtask

	function automatic logic [31:0] pair_worth(int t, int w);
		logic [15:0] dx, dy;
		logic [33:0] d2, r2;
		dx = (w_pos[w][31:16] > t_pos[t][31:16]) ? w_pos[w][31:16] - t_pos[t][31:16]
			: t_pos[t][31:16] - w_pos[w][31:16];
		dy = (w_pos[w][15:0] > t_pos[t][15:0]) ? w_pos[w][15:0] - t_pos[t][15:0]
			: t_pos[t][15:0] - w_pos[w][15:0];
		d2 = 34'(dx * dx) + 34'(dy * dy);
		r2 = 34'(w_rad[w] * w_rad[w]);
		if (d2 > r2)
			return '0;
		if (!({1'b0, w_start[w]} < t_end[t] && {1'b0, t_start[t]} < w_end[w]))
			return '0;
		return 32'(t_pay[t] * w_rate[w]);
	endfunction

	task automatic predict_arrival(input in_item_t a);
		int n, me, best_i;
		logic [31:0] best, c;
		out_item_t r;
		n = a.cmd ? int'(a.copies) : 1;
		if (n > Copies)
			n = Copies;
		for (int k = 0; k < n; k++) begin
			r = '0;
			best = '0;
			best_i = 0;
			if ((a.cmd ? n_workers : n_tasks) >= Depth) begin
				r.table_full = 1'b1;
			end else if (a.cmd) begin
				me = n_workers++;
				w_pos[me] = {a.pos_x, a.pos_y};
				w_rad[me] = a.reach;
				w_start[me] = a.arrival_time;
				w_end[me] = 21'(a.arrival_time) + 21'(a.duration);
				w_rate[me] = a.value;
				w_used[me] = 0;
				for (int i = 0; i < n_tasks; i++) begin
					if (t_used[i])
						continue;
					c = pair_worth(i, me);
					if (c > best) begin
						best = c;
						best_i = i;
					end
				end
				if (best != 0) begin
					w_used[me] = 1;
					t_used[best_i] = 1;
				end
			end else begin
				me = n_tasks++;
				t_pos[me] = {a.pos_x, a.pos_y};
				t_start[me] = a.arrival_time;
				t_end[me] = 21'(a.arrival_time) + 21'(a.duration);
				t_pay[me] = a.value;
				t_used[me] = 0;
				for (int i = 0; i < n_workers; i++) begin
					if (w_used[i])
						continue;
					c = pair_worth(me, i);
					if (c > best) begin
						best = c;
						best_i = i;
					end
				end
				if (best != 0) begin
					t_used[me] = 1;
					w_used[best_i] = 1;
				end
			end
			if (best != 0) begin
				utility = utility + 48'(best);
				r.matched = 1'b1;
				r.partner_index = best_i[7:0];
				r.pair_value = best;
			end
			r.total_utility = utility;
			r.copy_last = (k + 1 == n);
			expected_results.insert(expected_results.size(), r);
		end
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	// Driver.
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
			send_gap <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_arrival(in_ch.data);
				void'(pending_items.pop_front());
			end
			if (in_ch.valid && !in_ch.ready) begin
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_ch.valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				send_gap <= $urandom_range(1, 18);
				in_ch.valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				in_ch.valid <= 1'b1;
				in_ch.data <= pending_items[0];
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Monitor and sink stalls.
	int stall;
	out_item_t got, want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (expected_results.size() == 0) begin
					report("unexpected result", 64'(got.total_utility), 64'(0));
				end else begin
					want = expected_results.pop_front();
					if (got.matched !== want.matched)
						report("matched", 64'(got.matched), 64'(want.matched));
					if (got.partner_index !== want.partner_index)
						report("partner_index", 64'(got.partner_index),
							64'(want.partner_index));
					if (got.pair_value !== want.pair_value)
						report("pair_value", 64'(got.pair_value), 64'(want.pair_value));
					if (got.total_utility !== want.total_utility)
						report("total_utility", 64'(got.total_utility),
							64'(want.total_utility));
					if (got.table_full !== want.table_full)
						report("table_full", 64'(got.table_full), 64'(want.table_full));
					if (got.copy_last !== want.copy_last)
						report("copy_last", 64'(got.copy_last), 64'(want.copy_last));
				end
			end
			if (stall > 0) begin
				stall <= stall - 1;
				out_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall <= $urandom_range(1, 18);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	function automatic in_item_t arrival(input bit wk, input int px, input int py,
			input int rad, input int val, input int ncopies, input int t0, input int dur);
		in_item_t a;
		a.cmd = wk;
		a.pos_x = 16'(px);
		a.pos_y = 16'(py);
		a.reach = 16'(rad);
		a.value = 16'(val);
		a.copies = 5'(ncopies);
		a.arrival_time = 20'(t0);
		a.duration = 20'(dur);
		return a;
	endfunction

	// Most arrivals cluster in a small area and time span so that pairs form.
	function automatic in_item_t random_arrival();
		in_item_t a;
		a = in_item_t'({$urandom, $urandom, $urandom});
		if ($urandom_range(0, 9) != 0) begin
			a.pos_x = 16'(30000 + $urandom_range(0, 400));
			a.pos_y = 16'(30000 + $urandom_range(0, 400));
			a.reach = 16'($urandom_range(0, 500));
			a.arrival_time = 20'(5000 + $urandom_range(0, 3000));
			a.duration = 20'($urandom_range(0, 4000));
		end
		if ($urandom_range(0, 9) != 0)
			a.copies = 5'($urandom_range(1, 4));
		return a;
	endfunction

	initial begin
		in_item_t a;
		errors = 0;
		cycles = 0;
		stim_done = 0;
		calm = 0;
		n_tasks = 0;
		n_workers = 0;
		utility = '0;
		// Directed part: extremes, zero values, zero and excess copies, boundary cases.
		add_item(arrival(1, 0, 0, 0, 16'hFFFF, 0, 0, 0));
		add_item(arrival(0, 0, 0, 0, 16'hFFFF, 1, 0, 1));
		add_item(arrival(1, 0, 0, 0, 16'hFFFF, 1, 0, 1));
		add_item(arrival(0, 3, 4, 0, 16'h0100, 1, 10, 10));
		add_item(arrival(1, 0, 0, 5, 16'h8000, 2, 19, 5));
		add_item(arrival(1, 0, 0, 5, 16'h8000, 1, 20, 5));
		add_item(arrival(0, 3, 4, 0, 16'h0100, 1, 0, 20));
		add_item(arrival(0, 0, 0, 0, 16'h0000, 1, 0, 100));
		add_item(arrival(1, 0, 0, 9, 16'h0000, 3, 0, 100));
		add_item(arrival(0, 65535, 65535, 65535, 16'hFFFF, 31, 1048575, 1048575));
		add_item(arrival(1, 65535, 65535, 65535, 16'hFFFF, 31, 1048575, 1048575));
		add_item(arrival(1, 65535, 0, 65535, 16'hFFFF, 17, 1048570, 1048575));
		add_item(arrival(0, 0, 65535, 0, 16'h1234, 1, 1048574, 1048575));
		add_item(arrival(0, 10, 10, 0, 16'h0200, 1, 0, 50));
		add_item(arrival(0, 10, 10, 0, 16'h0300, 1, 0, 50));
		add_item(arrival(1, 10, 10, 0, 16'h0001, 1, 0, 50));
		for (int i = 0; i < 364; i++)
			add_item(random_arrival());
		// Further arrivals with many copies so that the worker table fills.
		for (int i = 0; i < 40; i++) begin
			a = random_arrival();
			a.copies = 5'(16);
			add_item(a);
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_items.size() < 30);
		calm = 1;
		wait (pending_items.size() == 0);
		stim_done = 1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("greedy_spatial_task_worker_matcher_top verification failed");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		wait (expected_results.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("greedy_spatial_task_worker_matcher_top verification clean");
		else
			$display("greedy_spatial_task_worker_matcher_top verification failed");
		$finish;
	end
endmodule
